[src/hbs_pkg.sv]
// ----------------------------------------------------------------------------
// hbs_pkg: shared definitions for the heightmap bilinear sampler
// Field widths, default parameter values, item codes and sequencer states.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // Default parameter values
  localparam int GRID_SIZE_DEF = 64;
  localparam int FRAC_BITS_DEF = 8;

  // Fixed field widths of the ports
  localparam int FUNC_W   = 1;
  localparam int ROWCOL_W = 6;
  localparam int H_W      = 8;
  localparam int POS_W    = 22;
  localparam int POS_FRAC = 8;
  localparam int CS_W     = 8;
  localparam int OUT_W    = 16;

  // Largest exact blend, 255.0 in Q8.8
  localparam logic [OUT_W-1:0] MAX_HEIGHT_Q88 = 16'hFF00;

  // Item codes carried on func
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_DONE
  } hbs_state_e;

endpackage

[src/heightmap_bilinear_sampler_unit.sv]
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_unit: bilinear height lookup on a terrain grid
// Holds a GRID_SIZE x GRID_SIZE grid of 8-bit heights in one RAM, takes
// height writes and position queries, returns Q8.8 blended heights.
// ----------------------------------------------------------------------------
// After reset the block is busy while it sweeps the height RAM to zero. A
// write word is taken whenever busy_o is low, busy_o stays low, and its
// acknowledgement shows on done_o in the next cycle. A query word raises
// busy_o through the two-lane radix-2 divider by cell_size, four corner
// reads through the single RAM port, whose read data and product registers
// feed the multiply-accumulate, and a rounding state; done_o pulses in the
// first cycle that busy_o is low again, and a new word may be taken in that
// cycle. Every result is a one-cycle strobe on done_o and is never held:
// the receiver must take it in that cycle.
// cfg_ready_o is always high; write cell_size only while busy_o is low.
module heightmap_bilinear_sampler_unit
  import hbs_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command side
  input  logic                start_i,
  output logic                busy_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [ROWCOL_W-1:0] cell_row_i,
  input  logic [ROWCOL_W-1:0] cell_col_i,
  input  logic [H_W-1:0]      height_in_i,
  input  logic [POS_W-1:0]    pos_x_i,
  input  logic [POS_W-1:0]    pos_z_i,
  // result side
  output logic                done_o,
  output logic [OUT_W-1:0]    height_out_o,
  output logic                was_query_o,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CS_W-1:0]     cfg_data_i
);

  localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(GRID_SIZE);
  localparam int QW     = POS_W + FRAC_BITS - POS_FRAC;  // quotient width
  localparam int CNT_W  = $clog2(QW + 1);
  localparam int W_W    = FRAC_BITS + 1;                 // weight width
  localparam int P_W    = H_W + W_W;
  localparam int ACC_W  = H_W + 2 * FRAC_BITS;
  localparam int SHIFT  = 2 * FRAC_BITS - POS_FRAC;

  localparam logic [W_W-1:0]    ONE      = W_W'(1) << FRAC_BITS;
  localparam logic [ACC_W:0]    HALF     = ((ACC_W + 1)'(1) << SHIFT) >> 1;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(GRID_SIZE - 1);
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(QW - 1);
  localparam logic [CNT_W-1:0]  RD_ISSUE = CNT_W'(4);
  localparam logic [CNT_W-1:0]  RD_LAST  = CNT_W'(5);

  // one restoring divide step: returns {remainder, shifted dividend/quotient}
  function automatic logic [CS_W+QW-1:0] div_step(input logic [CS_W-1:0] r,
                                                  input logic [QW-1:0]   n,
                                                  input logic [CS_W-1:0] d);
    logic [CS_W:0] trial;
    logic          qb;
    trial = {r, n[QW-1]};
    qb    = (trial >= {1'b0, d});
    if (qb) begin
      trial = trial - {1'b0, d};
    end
    return {trial[CS_W-1:0], n[QW-2:0], qb};
  endfunction

  // cell index from a quotient, saturated to the last cell
  function automatic logic [IDX_W-1:0] cell_idx(input logic [QW-1:0] q);
    logic [QW-FRAC_BITS-1:0] ip;
    ip = q[QW-1:FRAC_BITS];
    if (32'(ip) > GRID_SIZE - 1) begin
      return IDX_LAST;
    end
    return IDX_W'(ip);
  endfunction

  // neighbor index, wrapping at the edge
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    if (32'(i) + 1 >= GRID_SIZE) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  hbs_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CS_W-1:0]   cell_size_q;
  logic              done_q;
  logic              rd_vld_q, p_vld_q;
  logic [1:0]        rd_tag_q;
  logic              p_tag_q;
  logic [QW-1:0]     nx_q, nz_q;
  logic [CS_W-1:0]   rx_q, rz_q;
  logic [P_W-1:0]    p_q;
  logic [ACC_W-1:0]  acc_q;
  logic [OUT_W-1:0]  hout_q;
  logic              wq_q;

  logic              q_acc, w_acc, wr_in_grid, rd_en;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr, wr_addr, rd_addr;
  logic [H_W-1:0]    mem_wdata, mem_rdata;
  logic [CS_W-1:0]   dv;
  logic [CS_W+QW-1:0] stepx, stepz;
  logic [POS_W+FRAC_BITS-1:0] extx, extz;
  logic [IDX_W-1:0]  c0, c1, r0, r1, row_sel, col_sel;
  logic [FRAC_BITS-1:0] tx, tz;
  logic [W_W-1:0]    wx, wz;
  logic [1:0]        tag;
  logic [ACC_W:0]    rnd, res;
  logic [OUT_W-1:0]  res_sat;

  // accept decode
  assign q_acc = start_i && !busy_o && (func_i == FUNC_QUERY);
  assign w_acc = start_i && !busy_o && (func_i == FUNC_WRITE);
  assign wr_in_grid = (32'(cell_row_i) < GRID_SIZE) && (32'(cell_col_i) < GRID_SIZE);
  assign wr_addr = ADDR_W'(ADDR_W'(cell_row_i) * ADDR_W'(GRID_SIZE)) + ADDR_W'(cell_col_i);

  // divider lanes
  assign dv    = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;
  assign stepx = div_step(rx_q, nx_q, dv);
  assign stepz = div_step(rz_q, nz_q, dv);
  assign extx  = {pos_x_i, {FRAC_BITS{1'b0}}};
  assign extz  = {pos_z_i, {FRAC_BITS{1'b0}}};

  // corner indices and fractions, held in the quotient registers
  assign c0 = cell_idx(nx_q);
  assign r0 = cell_idx(nz_q);
  assign c1 = next_idx(c0);
  assign r1 = next_idx(r0);
  assign tx = nx_q[FRAC_BITS-1:0];
  assign tz = nz_q[FRAC_BITS-1:0];

  // corner read address: tag bit 0 picks the next column, bit 1 the next row
  assign tag     = cnt_q[1:0];
  assign row_sel = tag[1] ? r1 : r0;
  assign col_sel = tag[0] ? c1 : c0;
  assign rd_addr = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(GRID_SIZE)) + ADDR_W'(col_sel);

  // blend weights for the word in flight
  assign wx = rd_tag_q[0] ? {1'b0, tx} : ONE - {1'b0, tx};
  assign wz = p_tag_q     ? {1'b0, tz} : ONE - {1'b0, tz};

  // round half up to Q8.8, then saturate
  assign rnd     = (ACC_W + 1)'(acc_q) + HALF;
  assign res     = rnd >> SHIFT;
  assign res_sat = (res > (ACC_W + 1)'(16'hFFFF)) ? 16'hFFFF : res[OUT_W-1:0];

  // sequencer next state and RAM control
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_addr  = rd_addr;
    mem_wdata = '0;
    rd_en     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + ADDR_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_acc) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end else if (w_acc && wr_in_grid) begin
          mem_we    = 1'b1;
          mem_addr  = wr_addr;
          mem_wdata = height_in_i;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = ST_READ;
          cnt_d   = '0;
        end
      end
      ST_READ: begin
        rd_en = (cnt_q < RD_ISSUE);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == RD_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      cell_size_q <= CS_W'(1);
      done_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      p_vld_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      clr_q    <= clr_d;
      done_q   <= w_acc || (state_q == ST_DONE);
      rd_vld_q <= rd_en;
      p_vld_q  <= rd_vld_q;
      if (cfg_valid_i && cfg_ready_o) begin
        cell_size_q <= cfg_data_i;
      end
    end
  end

  // datapath: divider, multiply-accumulate, result word
  always_ff @(posedge clk_i) begin
    if (q_acc) begin
      nx_q  <= extx[POS_W+FRAC_BITS-1:POS_FRAC];
      nz_q  <= extz[POS_W+FRAC_BITS-1:POS_FRAC];
      rx_q  <= '0;
      rz_q  <= '0;
      acc_q <= '0;
    end else if (state_q == ST_DIV) begin
      {rx_q, nx_q} <= stepx;
      {rz_q, nz_q} <= stepz;
    end else if (p_vld_q) begin
      acc_q <= acc_q + ACC_W'(ACC_W'(p_q) * ACC_W'(wz));
    end
    rd_tag_q <= tag;
    p_tag_q  <= rd_tag_q[1];
    p_q      <= P_W'(P_W'(mem_rdata) * P_W'(wx));
    if (w_acc) begin
      hout_q <= '0;
      wq_q   <= 1'b0;
    end else if (state_q == ST_DONE) begin
      hout_q <= res_sat;
      wq_q   <= 1'b1;
    end
  end

  // height grid
  hbs_ram #(
    .WIDTH (H_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign height_out_o = hout_q;
  assign was_query_o  = wq_q;
  assign cfg_ready_o  = 1'b1;

endmodule

[src/hbs_ram.sv]
// ----------------------------------------------------------------------------
// hbs_ram: single-port synchronous RAM
// One read or write per cycle at one address, read data registered.
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4096,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/hbs_checker.sv]
// ----------------------------------------------------------------------------
// hbs_checker: port-level checks for the heightmap bilinear sampler
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module hbs_checker
  import hbs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic [FUNC_W-1:0] func_i,
  input logic              done_o,
  input logic [OUT_W-1:0]  height_out_o,
  input logic              was_query_o
);

  // a query word always holds the block busy in the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == FUNC_QUERY) |=> busy_o)
    else $error("query word did not raise busy");

  // a write word is acknowledged in the next cycle with a zero word
  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == FUNC_WRITE) |=>
      (done_o && !was_query_o && height_out_o == '0))
    else $error("write word not acknowledged");

  // results only appear while the block is not busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while busy");

  // a query answer follows a busy stretch
  a_query_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && was_query_o) |-> $past(busy_o))
    else $error("query answer without busy stretch");

  // a blend of 8-bit heights never exceeds 255.0
  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && was_query_o) |-> (height_out_o <= MAX_HEIGHT_Q88))
    else $error("blended height out of range");

endmodule

bind heightmap_bilinear_sampler_unit hbs_checker u_hbs_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for heightmap_bilinear_sampler_unit
// Drives height writes and position queries through the start/busy command
// port, predicts each result from a local copy of the height grid and the
// cell size, and checks every done_o strobe against the oldest expectation.
// Runs a short directed set, then random phases over several cell sizes.
// ----------------------------------------------------------------------------
module testbench;
  import hbs_pkg::*;

  localparam int          GRID_N          = GRID_SIZE_DEF;
  localparam int          FRAC_N          = FRAC_BITS_DEF;
  localparam int          BLEND_SHIFT     = 2 * FRAC_N - POS_FRAC;
  localparam int          HALF_PERIOD     = 6;
  localparam int          RESET_CYCLES    = 5;
  localparam int          NUM_PHASES      = 8;
  localparam int          WORDS_PER_PHASE = 225;
  localparam int          TAIL_CYCLES     = 64;
  localparam int          MAX_PRINTED     = 100;
  localparam longint      CYCLE_LIMIT     = 600000;
  localparam logic [POS_W-1:0] POS_MAX    = '1;

  // one command word as presented on the start port
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [ROWCOL_W-1:0] row;
    logic [ROWCOL_W-1:0] col;
    logic [H_W-1:0]      height;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_z;
    bit                  drain_first;  // hold off until all results are in
  } cmd_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] height;
    logic             was_query;
  } height_result_t;

  // DUT signals
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  logic [FUNC_W-1:0]   func_i      = FUNC_WRITE;
  logic [ROWCOL_W-1:0] cell_row_i  = '0;
  logic [ROWCOL_W-1:0] cell_col_i  = '0;
  logic [H_W-1:0]      height_in_i = '0;
  logic [POS_W-1:0]    pos_x_i     = '0;
  logic [POS_W-1:0]    pos_z_i     = '0;
  logic                done_o;
  logic [OUT_W-1:0]    height_out_o;
  logic                was_query_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CS_W-1:0]     cfg_data_i  = '0;

  // bench state
  cmd_word_t      cmd_q[$];
  height_result_t height_expect_q[$];
  logic [H_W-1:0] height_model [GRID_N*GRID_N];
  logic [CS_W-1:0] cell_size_model = 8'd1;
  bit             word_taken = 1'b0;
  int             idle_pct = 0;
  int             error_count = 0;
  int             write_acks = 0;
  int             queries_checked = 0;
  int             cfg_writes = 0;
  longint         cycle_count = 0;

  heightmap_bilinear_sampler_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .height_in_i  (height_in_i),
    .pos_x_i      (pos_x_i),
    .pos_z_i      (pos_z_i),
    .done_o       (done_o),
    .height_out_o (height_out_o),
    .was_query_o  (was_query_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint unsigned grid_at(longint unsigned row, longint unsigned col);
    return longint'(height_model[row * GRID_N + col]);
  endfunction

  // bilinear blend of the four corners around (px, pz), Q8.8 out
  function automatic logic [OUT_W-1:0] blend_height(logic [POS_W-1:0] px,
                                                    logic [POS_W-1:0] pz);
    longint unsigned scale, divisor, qx, qz, tx, tz;
    longint unsigned c0, c1, r0, r1, sum, res;
    scale   = 64'd1 << FRAC_N;
    divisor = (cell_size_model == '0) ? 64'd1 : longint'(cell_size_model);
    divisor = divisor << POS_FRAC;
    qx = px;
    qz = pz;
    qx = (qx << FRAC_N) / divisor;
    qz = (qz << FRAC_N) / divisor;
    tx = qx & (scale - 1);
    tz = qz & (scale - 1);
    c0 = qx >> FRAC_N;
    r0 = qz >> FRAC_N;
    // saturate past the grid, keep the fraction
    if (c0 > GRID_N - 1) c0 = GRID_N - 1;
    if (r0 > GRID_N - 1) r0 = GRID_N - 1;
    // neighbor past the edge wraps to 0
    c1 = (c0 + 1 >= GRID_N) ? 0 : c0 + 1;
    r1 = (r0 + 1 >= GRID_N) ? 0 : r0 + 1;
    sum = grid_at(r0, c0) * (scale - tx) * (scale - tz)
        + grid_at(r0, c1) * tx * (scale - tz)
        + grid_at(r1, c1) * tx * tz
        + grid_at(r1, c0) * (scale - tx) * tz;
    if (BLEND_SHIFT > 0) res = (sum + (64'd1 << (BLEND_SHIFT - 1))) >> BLEND_SHIFT;
    else res = sum;
    if (res > 64'hFFFF) res = 64'hFFFF;
    return OUT_W'(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want,
               cycle_count);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // rows/cols at the low corner and at the far edge, where wraps happen
  function automatic int hot_index();
    int v;
    v = $urandom_range(0, 7);
    return (v < 6) ? v : GRID_N - 8 + v;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos(int unsigned csd);
    int unsigned unit, k;
    unit = 256 * csd;
    k    = $urandom_range(0, 99);
    if (k < 45) return POS_W'(hot_index() * unit + $urandom_range(0, unit - 1));
    else if (k < 70) return POS_W'($urandom_range(0, GRID_N * unit - 1));
    else if (k < 80) return POS_W'($urandom_range(0, GRID_N - 1) * unit);
    else if (k < 90) return POS_W'($urandom_range(GRID_N * unit, int'(POS_MAX)));
    else return POS_W'($urandom);
  endfunction

  function automatic cmd_word_t rand_cmd();
    cmd_word_t   w;
    int unsigned csd, k;
    csd = (cell_size_model == '0) ? 1 : cell_size_model;
    k   = $urandom_range(0, 99);
    w.func   = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_QUERY;
    w.row    = $urandom_range(0, 1) ? ROWCOL_W'(hot_index()) : ROWCOL_W'($urandom);
    w.col    = $urandom_range(0, 1) ? ROWCOL_W'(hot_index()) : ROWCOL_W'($urandom);
    w.height = (k < 5) ? '0 : (k < 10) ? '1 : H_W'($urandom);
    w.pos_x  = rand_pos(csd);
    w.pos_z  = rand_pos(csd);
    w.drain_first = ($urandom_range(0, 49) == 0);
    return w;
  endfunction

  task automatic push_write(input int row, input int col, input int height);
    cmd_word_t w;
    w = '{func: FUNC_WRITE, row: ROWCOL_W'(row), col: ROWCOL_W'(col),
          height: H_W'(height), pos_x: POS_MAX, pos_z: POS_MAX, drain_first: 1'b0};
    cmd_q.push_back(w);
  endtask

  task automatic push_query(input int px, input int pz);
    cmd_word_t w;
    w = '{func: FUNC_QUERY, row: '1, col: '1, height: '1,
          pos_x: POS_W'(px), pos_z: POS_W'(pz), drain_first: 1'b0};
    cmd_q.push_back(w);
  endtask

  // block idle: nothing queued, nothing presented, nothing outstanding
  task automatic wait_drained();
    while (cmd_q.size() != 0 || start_i || height_expect_q.size() != 0 || busy_o)
      @(posedge clk_i);
  endtask

  task automatic write_cell_size(input int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CS_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cell_size_model = CS_W'(value);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued words at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_proc
    bit gap;
    gap = ($urandom_range(0, 99) < idle_pct);
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || word_taken) begin
      if (start_i) cmd_q.delete(0);
      if (cmd_q.size() != 0 && !gap &&
          !(cmd_q[0].drain_first && height_expect_q.size() != 0)) begin
        func_i      <= cmd_q[0].func;
        cell_row_i  <= cmd_q[0].row;
        cell_col_i  <= cmd_q[0].col;
        height_in_i <= cmd_q[0].height;
        pos_x_i     <= cmd_q[0].pos_x;
        pos_z_i     <= cmd_q[0].pos_z;
        start_i     <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks strobed results, predicts accepted words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    height_result_t exp_r;
    if (rst_ni) begin
      // check first: a result always belongs to an older word
      if (done_o) begin
        if (height_expect_q.size() == 0) begin
          report_mismatch("result with nothing expected", height_out_o, '0);
        end else begin
          exp_r = height_expect_q.pop_front();
          if (height_out_o !== exp_r.height)
            report_mismatch("height_out", height_out_o, exp_r.height);
          if (was_query_o !== exp_r.was_query)
            report_mismatch("was_query", OUT_W'(was_query_o), OUT_W'(exp_r.was_query));
          if (exp_r.was_query) queries_checked++;
          else write_acks++;
        end
      end
      if (start_i && !busy_o) begin
        word_taken <= 1'b1;
        if (func_i == FUNC_WRITE) begin
          if (cell_row_i < GRID_N && cell_col_i < GRID_N)
            height_model[cell_row_i * GRID_N + cell_col_i] = height_in_i;
          exp_r = '{height: '0, was_query: 1'b0};
        end else begin
          exp_r = '{height: blend_height(pos_x_i, pos_z_i), was_query: 1'b1};
        end
        height_expect_q.push_back(exp_r);
      end else begin
        word_taken <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               height_expect_q.size());
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_proc
    int cs_plan [NUM_PHASES];
    int idle_plan [NUM_PHASES];
    for (int i = 0; i < GRID_N * GRID_N; i++) height_model[i] = '0;
    cs_plan   = '{1, 255, 7, 0, 2, 128, 1, 3};
    cs_plan[2] = $urandom_range(1, 254);
    cs_plan[6] = $urandom_range(1, 254);
    idle_plan = '{11, 11, 11, 63, 63, 63, 0, 0};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 11;

    // directed: unit cells, corners, fractions, wraps, saturation
    wait_drained();
    write_cell_size(1);
    push_query(0, 0);
    push_write(0, 0, 255);
    push_write(0, GRID_N - 1, 200);
    push_write(GRID_N - 1, 0, 100);
    push_write(GRID_N - 1, GRID_N - 1, 50);
    push_write(0, 1, 10);
    push_write(1, 0, 20);
    push_write(1, 1, 30);
    push_query(0, 0);
    push_query(8'h80, 8'h80);
    push_query(8'hFF, 8'hFF);
    push_query((GRID_N - 1) * 256 + 8'h80, (GRID_N - 1) * 256 + 8'h80);
    push_query((GRID_N - 1) * 256 + 8'h40, 8'h20);
    push_query(int'(POS_MAX), int'(POS_MAX));
    push_query(int'(POS_MAX), 0);
    push_write(0, 0, 0);
    wait_drained();
    // zero cell size behaves as one
    write_cell_size(0);
    push_query(8'h80, 8'h80);
    push_query((GRID_N - 1) * 256 + 8'hC0, 8'h7F);
    wait_drained();
    // widest cells
    write_cell_size(255);
    push_query(int'(POS_MAX), int'(POS_MAX));
    push_query(255 * 128, (GRID_N - 1) * 256 * 255 + 255 * 200);
    wait_drained();

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cell_size(cs_plan[p]);
      idle_pct = idle_plan[p];
      for (int n = 0; n < WORDS_PER_PHASE; n++) cmd_q.push_back(rand_cmd());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("checked %0d write acks and %0d queries over %0d cell-size writes",
             write_acks, queries_checked, cfg_writes);
    $display("sender idle rates 11%%, 63%% and none; %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
